// ===== sv/signed_integer_to_base_digits_defines.svh =====
// assertion macros used by the checker file
`ifndef SIGNED_INTEGER_TO_BASE_DIGITS_DEFINES_SVH
`define SIGNED_INTEGER_TO_BASE_DIGITS_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SITBD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SITBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sitbd_pkg.sv =====
// shared types, constants and the digit-to-ascii function
`timescale 1ns / 1ps

package sitbd_pkg;

  localparam int NUM_W             = 64;
  localparam int RADIX_W           = 6;
  localparam int DIGIT_W           = 6;
  localparam int CHAR_W            = 7;
  localparam int STEP_W            = $clog2(NUM_W);
  localparam int DIGIT_STORE_DEPTH = 64;

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

  localparam logic [CHAR_W-1:0]  CHAR_ZERO    = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  CHAR_UPPER_A = CHAR_W'(65);
  localparam logic [CHAR_W-1:0]  CHAR_LOWER_A = CHAR_W'(97);
  localparam logic [CHAR_W-1:0]  CHAR_MINUS   = CHAR_W'(45);
  localparam logic [DIGIT_W-1:0] DIGIT_TEN    = DIGIT_W'(10);

  localparam logic [NUM_W-1:0] MAG_MAX = {1'b0, {(NUM_W-1){1'b1}}};

  typedef struct packed {
    logic signed [NUM_W-1:0] number;
    logic [RADIX_W-1:0]      radix;
    logic                    upper_case;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } out_item_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic               done;
    logic [DIGIT_W-1:0] rem;
  } div_stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] base_ch;
    base_ch = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
    if (d < DIGIT_TEN) begin
      return CHAR_ZERO + CHAR_W'(d);
    end
    return base_ch + CHAR_W'(d - DIGIT_TEN);
  endfunction

endpackage

// ===== sv/signed_integer_to_base_digits.sv =====
// Each digit takes one pass of the single divider (one quotient bit per cycle),
// and each emitted character is held in S_OUT until out_stall is low.
// Throughput: one number at a time; in_stall stays high from acceptance until
// the last character transaction.
// Reset: synchronous active-low rst_n returns the sequencer to idle and drops
// out_valid; the digit store needs no clearing since every digit is written first.
`timescale 1ns / 1ps

module signed_integer_to_base_digits #(
  parameter int DIGIT_STORE_DEPTH = sitbd_pkg::DIGIT_STORE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sitbd_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sitbd_pkg::out_item_t  out_data
);

  localparam int AW = (DIGIT_STORE_DEPTH > 1) ? $clog2(DIGIT_STORE_DEPTH) : 1;
  localparam int CW = $clog2(DIGIT_STORE_DEPTH + 1);
  localparam int NW = sitbd_pkg::NUM_W;
  localparam int RW = sitbd_pkg::RADIX_W;
  localparam int DW = sitbd_pkg::DIGIT_W;
  localparam int XW = sitbd_pkg::CHAR_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_LD   = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          neg_r, neg_nxt;
  logic          upper_r, upper_nxt;
  logic [RW-1:0] radix_r, radix_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [XW-1:0] out_char_r, out_char_nxt;
  logic          out_last_r, out_last_nxt;

  logic          accept;
  logic          div_start;
  logic [NW-1:0] div_dividend;
  logic [RW-1:0] div_divisor;
  logic [NW-1:0] div_quo;
  sitbd_pkg::div_stat_t div_stat;

  logic          ram_we;
  logic [DW-1:0] ram_rdata;
  logic [NW-1:0] in_mag;
  logic [RW-1:0] in_radix;
  logic          room;
  logic [CW-1:0] cnt_inc;

  assign accept = in_valid && !in_stall;
  assign room   = cnt_r < CW'(DIGIT_STORE_DEPTH);
  assign cnt_inc = room ? cnt_r + 1'b1 : cnt_r;

  // input conditioning: clamp radix, magnitude with saturation of the most negative value
  always_comb begin
    in_radix = in_data.radix;
    if (in_data.radix < sitbd_pkg::RADIX_MIN) begin
      in_radix = sitbd_pkg::RADIX_MIN;
    end else if (in_data.radix > sitbd_pkg::RADIX_MAX) begin
      in_radix = sitbd_pkg::RADIX_MAX;
    end
    in_mag = in_data.number[NW-1] ? (~in_data.number + 1'b1) : in_data.number;
    if (in_mag > sitbd_pkg::MAG_MAX) begin
      in_mag = sitbd_pkg::MAG_MAX;
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    neg_nxt       = neg_r;
    upper_nxt     = upper_r;
    radix_nxt     = radix_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    div_start     = 1'b0;
    div_dividend  = div_quo;
    div_divisor   = radix_r;
    ram_we        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          neg_nxt      = in_data.number[NW-1];
          upper_nxt    = in_data.upper_case;
          radix_nxt    = in_radix;
          cnt_nxt      = '0;
          div_start    = 1'b1;
          div_dividend = in_mag;
          div_divisor  = in_radix;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          ram_we  = room;
          cnt_nxt = cnt_inc;
          if (div_quo != '0) begin
            div_start = 1'b1;
          end else begin
            idx_nxt = AW'(cnt_inc - 1'b1);
            if (neg_r) begin
              out_valid_nxt = 1'b1;
              out_char_nxt  = sitbd_pkg::CHAR_MINUS;
              out_last_nxt  = 1'b0;
              state_nxt     = S_OUT;
            end else begin
              state_nxt = S_RD;
            end
          end
        end
      end
      S_RD: begin
        state_nxt = S_LD;
      end
      S_LD: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = sitbd_pkg::digit_char(ram_rdata, upper_r);
        out_last_nxt  = (idx_r == '0);
        if (idx_r != '0) begin
          idx_nxt = idx_r - 1'b1;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = out_last_r ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      neg_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      neg_r       <= neg_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    upper_r    <= upper_nxt;
    radix_r    <= radix_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  sitbd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  sitbd_ram #(
    .WIDTH (DW),
    .DEPTH (DIGIT_STORE_DEPTH)
  ) u_digit_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (div_stat.rem),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_data.character = out_char_r;
  assign out_data.last      = out_last_r;

endmodule

// ===== sv/sitbd_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module sitbd_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/sitbd_div.sv =====
// bit-serial restoring divider: 64-bit dividend by a small radix
`timescale 1ns / 1ps

module sitbd_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [sitbd_pkg::NUM_W-1:0]       dividend,
  input  logic [sitbd_pkg::RADIX_W-1:0]     divisor,
  output logic [sitbd_pkg::NUM_W-1:0]       quotient,
  output sitbd_pkg::div_stat_t              stat
);

  localparam int NW = sitbd_pkg::NUM_W;
  localparam int DW = sitbd_pkg::DIGIT_W;
  localparam int SW = sitbd_pkg::STEP_W;

  logic [NW-1:0]              quo_r, quo_nxt;
  logic [DW-1:0]              rem_r, rem_nxt;
  logic [sitbd_pkg::RADIX_W-1:0] dvs_r;
  logic [SW-1:0]              step_r;
  logic                       busy_r, done_r;
  logic [DW:0]                trial;
  logic                       fits;

  // one quotient bit per cycle
  always_comb begin
    trial   = {rem_r, quo_r[NW-1]};
    fits    = trial >= {1'b0, dvs_r};
    rem_nxt = fits ? DW'(trial - {1'b0, dvs_r}) : DW'(trial);
    quo_nxt = {quo_r[NW-2:0], fits};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && (step_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        step_r <= SW'(NW - 1);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient  = quo_r;
  assign stat.done = done_r;
  assign stat.rem  = rem_r;

endmodule

// ===== sv/sitbd_chk.sv =====
// port-level checker for the number-to-text block, bound to the top level
`timescale 1ns / 1ps
`include "signed_integer_to_base_digits_defines.svh"

module sitbd_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input sitbd_pkg::out_item_t out_data
);

  // a stalled result holds its payload
  `SITBD_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_data), "stalled result changed")

  // an accepted number keeps the input closed on the next cycle
  `SITBD_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
    "input open right after acceptance")

  // no new number is taken while characters are going out
  `SITBD_ASSERT_NOW(a_no_accept_on_emit, out_valid, in_stall, "input open while emitting")

  // no result is presented straight after the last character of a text is taken
  `SITBD_ASSERT_NEXT(a_quiet_after_last, out_valid && !out_stall && out_data.last,
    !out_valid, "result after last character")

endmodule

bind signed_integer_to_base_digits sitbd_chk u_sitbd_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== sim/tb.sv =====
// self-checking testbench for the signed integer to base digits converter
`timescale 1ns / 1ps

module tb;
  import sitbd_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int RESET_LEN   = 8;
  localparam int MAX_WAIT    = 17;
  localparam int REPORT_MAX  = 10;
  localparam int RANDOM_NUMS = 100;
  localparam int TAIL_CYCLES = 300;
  localparam int CYCLE_LIMIT = 3_000_000;

  localparam logic signed [NUM_W-1:0] NUM_MAX = MAG_MAX;
  localparam logic signed [NUM_W-1:0] NUM_MIN = ~MAG_MAX;

  // scoreboard: text predictor plus queue of expected characters
  class digit_text_scoreboard;
    out_item_t   expected_chars[$];
    int unsigned error_count;

    function void flag_error(string msg);
      error_count++;
      if (error_count <= REPORT_MAX) begin
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
    endfunction

    // accepted number: build its text, sign first, top digit first
    function void note_number(in_item_t item);
      logic [NUM_W-1:0]   mag;
      logic [NUM_W-1:0]   base;
      logic [DIGIT_W-1:0] digits[$];
      logic [DIGIT_W-1:0] d;
      out_item_t          ch;
      int                 i;
      base = NUM_W'(item.radix);
      if (base < NUM_W'(RADIX_MIN)) begin
        base = NUM_W'(RADIX_MIN);
      end
      if (base > NUM_W'(RADIX_MAX)) begin
        base = NUM_W'(RADIX_MAX);
      end
      mag = item.number[NUM_W-1] ? (~item.number + 1'b1) : item.number;
      // most negative value saturates to the largest magnitude
      if (mag > MAG_MAX) begin
        mag = MAG_MAX;
      end
      do begin
        d = DIGIT_W'(mag % base);
        mag = mag / base;
        if (digits.size() < DIGIT_STORE_DEPTH) begin
          digits.push_back(d);
        end
      end while (mag != '0);
      if (item.number[NUM_W-1]) begin
        ch.character = CHAR_MINUS;
        ch.last      = 1'b0;
        expected_chars.push_back(ch);
      end
      for (i = digits.size() - 1; i >= 0; i--) begin
        if (digits[i] < DIGIT_TEN) begin
          ch.character = CHAR_ZERO + CHAR_W'(digits[i]);
        end else begin
          ch.character = (item.upper_case ? CHAR_UPPER_A : CHAR_LOWER_A)
                         + CHAR_W'(digits[i] - DIGIT_TEN);
        end
        ch.last = (i == 0);
        expected_chars.push_back(ch);
      end
    endfunction

    // one character transaction against the oldest expectation
    function void check_char(out_item_t got);
      out_item_t want;
      if (expected_chars.size() == 0) begin
        flag_error($sformatf("unexpected char 0x%02h last %0b", got.character, got.last));
        return;
      end
      want = expected_chars.pop_front();
      if (got.character !== want.character) begin
        flag_error($sformatf("char expected 0x%02h got 0x%02h",
                             want.character, got.character));
      end
      if (got.last !== want.last) begin
        flag_error($sformatf("last expected %0b got %0b on char 0x%02h",
                             want.last, got.last, want.character));
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  digit_text_scoreboard sb = new();
  bit          no_idle   = 1'b0;
  int          out_hold  = 0;
  int unsigned cycle_count = 0;

  signed_integer_to_base_digits dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // offer one number, return at the edge that accepts it
  task automatic offer_number(logic signed [NUM_W-1:0] num, int radix, bit upper);
    in_item_t item;
    int       gap;
    item.number     = num;
    item.radix      = RADIX_W'(radix);
    item.upper_case = upper;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_number(item);
  endtask

  // result side: check transactions, stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        sb.check_char(out_data);
        out_hold = draw_wait();
      end else if (!out_valid && out_hold == 0 && $urandom_range(0, 7) == 0) begin
        out_hold = draw_wait();
      end
      if (out_hold > 0) begin
        out_stall <= 1'b1;
        out_hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // stimulus
  initial begin
    logic [NUM_W-1:0] raw;
    int               width;
    int               radix;
    int               n;

    repeat (RESET_LEN) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero, small values, extremes, clamped radix, letter case
    offer_number('0, 10, 1'b0);
    offer_number(64'sd1, 10, 1'b0);
    offer_number(-64'sd1, 10, 1'b1);
    offer_number(NUM_MAX, 2, 1'b0);
    offer_number(NUM_MAX, 36, 1'b1);
    offer_number(NUM_MIN, 2, 1'b0);
    offer_number(NUM_MIN, 16, 1'b1);
    offer_number(-NUM_MAX, 2, 1'b1);
    offer_number(-NUM_MAX, 36, 1'b0);
    offer_number(64'sd5, 0, 1'b0);
    offer_number(-64'sd6, 1, 1'b1);
    offer_number(64'sd1295, 37, 1'b1);
    offer_number(-64'sd1295, 63, 1'b0);
    offer_number(64'sd35, 36, 1'b1);
    offer_number(64'sd35, 36, 1'b0);
    offer_number(64'sd10, 11, 1'b0);
    offer_number(64'sd9, 11, 1'b1);
    offer_number(64'sh0123_4567_89AB_CDEF, 16, 1'b1);
    offer_number(-64'sh0123_4567_89AB_CDEF, 16, 1'b0);
    offer_number(-64'sd123456789, 7, 1'b1);
    offer_number(64'sh5555_5555_5555_5555, 3, 1'b0);
    offer_number('0, 63, 1'b1);

    // random: mostly short values, some full width, a stretch with no idle gaps
    for (n = 0; n < RANDOM_NUMS; n++) begin
      no_idle = (n >= 40 && n < 60);
      width = ($urandom_range(0, 4) == 0) ? $urandom_range(0, NUM_W)
                                          : $urandom_range(0, 24);
      raw = {$urandom, $urandom};
      if (width < NUM_W) begin
        raw = raw & ((64'd1 << width) - 64'd1);
      end
      if ($urandom_range(0, 1) == 1) begin
        raw = ~raw + 64'd1;
      end
      radix = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                          : $urandom_range(2, 36);
      offer_number(raw, radix, 1'($urandom_range(0, 1)));
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    // drain outstanding characters, then a quiet tail
    while (sb.expected_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/sitbd_pkg.sv
sv/sitbd_ram.sv
sv/sitbd_div.sv
sv/signed_integer_to_base_digits.sv
sv/sitbd_chk.sv
sim/tb.sv
